### src/fcstm_pkg.sv
package fcstm_pkg;

   localparam int unsigned CHANNELS     = 4;
   localparam int unsigned BASE_CLOCK   = 3072000;
   localparam int unsigned FREQ_SPAN    = 2048;
   localparam int unsigned SWEEP_UNIT   = 8192;

   // base clock already divided by the <<5 of the span and by the sweep unit
   localparam logic [16:0] SPAN_DIVIDEND  = 17'(BASE_CLOCK / 32);
   localparam logic [16:0] SWEEP_DIVIDEND = 17'(BASE_CLOCK / SWEEP_UNIT);
   localparam logic [16:0] SAMPLE_RATE_RESET = 17'd44100;

   localparam int unsigned DIV_WIDTH = 17;

   localparam logic [7:0] ADDR_FREQ_BASE = 8'h80;
   localparam logic [7:0] ADDR_VOL_BASE  = 8'h88;
   localparam logic [7:0] ADDR_SWEEP_AMT = 8'h8C;
   localparam logic [7:0] ADDR_SWEEP_TIM = 8'h8D;
   localparam logic [7:0] ADDR_CONTROL   = 8'h90;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   localparam logic [15:0] TONE_LEVEL = 16'd16;

endpackage

### src/four_channel_square_tone_mixer_core.sv
// Four-channel square-tone mixer.
//
// Input channel (req_): one word is either a bus write (req_operation low,
// req_address/req_write_data) or a sample tick (req_operation high). Each tick
// gives exactly one result word on rsp_ (left and right signed samples);
// writes give none. csr_write_enable/csr_write_data set the sample rate.
//
// Timing: a plain write does not hold off the next word. A tick's result is
// registered in the cycle after acceptance. A frequency or sweep-time write, and a
// tick on which the sweep reloads channel 2, start a period calculation: the period is
// found by two back-to-back passes of one restoring divider (one quotient bit a
// cycle), and req_stall stays high until both passes are done.
//
// Reset clears all channel state and sets the sample rate to 44100.
// When the receiver stalls, the result word holds on rsp_, and req_stall is
// raised so that no further word is taken until the pending result has gone.
module four_channel_square_tone_mixer_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_operation,
   input  logic [7:0]         req_address,
   input  logic [7:0]         req_write_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_left_sample,
   output logic signed [15:0] rsp_right_sample,
   input  logic               csr_write_enable,
   input  logic [16:0]        csr_write_data
);

   localparam int unsigned NCH = fcstm_pkg::CHANNELS;

   // sequencer codes
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIVA = 2'd1; // span or sweep quotient
   localparam logic [1:0] ST_DIVB = 2'd2; // sample rate over that quotient

   logic [1:0]  state_ff, state_in;
   logic [16:0] sample_rate_ff, sample_rate_in;

   logic [10:0] freq_ff     [NCH];
   logic [10:0] freq_in     [NCH];
   logic [11:0] period_ff   [NCH];
   logic [11:0] period_in   [NCH];
   logic [11:0] pos_ff      [NCH];
   logic [11:0] pos_in      [NCH];
   logic [3:0]  vol_l_ff    [NCH];
   logic [3:0]  vol_l_in    [NCH];
   logic [3:0]  vol_r_ff    [NCH];
   logic [3:0]  vol_r_in    [NCH];
   logic [NCH-1:0] enable_ff, enable_in;
   logic [NCH-1:0] neg_ff, neg_in;
   logic [7:0]  voice_ff, voice_in;
   logic [2:0]  mode_ff, mode_in;
   logic [7:0]  sweep_amt_ff, sweep_amt_in;
   logic [16:0] sweep_int_ff, sweep_int_in;
   logic [16:0] sweep_cnt_ff, sweep_cnt_in;

   // shared divider
   logic [16:0] rem_ff, rem_in;
   logic [16:0] quo_ff, quo_in;
   logic [16:0] den_ff, den_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        tgt_sweep_ff, tgt_sweep_in;
   logic [1:0]  tgt_chan_ff, tgt_chan_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] left_ff, left_in;
   logic signed [15:0] right_ff, right_in;

   logic        req_take;
   logic        rsp_take;
   logic [17:0] trial;
   logic        trial_ge;
   logic [16:0] quotient;
   logic        div_last;

   assign rsp_take  = rsp_valid_ff & ~rsp_stall;
   // hold every word while the divider is busy or a stalled result is still waiting
   assign req_stall = (state_ff != ST_IDLE) | (rsp_valid_ff & rsp_stall);
   assign req_take  = req_valid & ~req_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_left_sample  = left_ff;
   assign rsp_right_sample = right_ff;

   // one restoring step a cycle
   assign trial    = {rem_ff, quo_ff[16]};
   assign trial_ge = trial >= {1'b0, den_ff};
   assign quotient = {quo_ff[15:0], trial_ge};
   assign div_last = cnt_ff == 5'(fcstm_pkg::DIV_WIDTH - 1);

   always_comb begin
      logic [1:0]  ch;
      logic [10:0] nf;
      logic [11:0] step_pos;
      logic        active;
      logic signed [15:0] lev;
      logic signed [15:0] sum_l;
      logic signed [15:0] sum_r;
      logic [16:0] sc;

      state_in       = state_ff;
      sample_rate_in = csr_write_enable ? csr_write_data : sample_rate_ff;
      freq_in        = freq_ff;
      period_in      = period_ff;
      pos_in         = pos_ff;
      vol_l_in       = vol_l_ff;
      vol_r_in       = vol_r_ff;
      enable_in      = enable_ff;
      neg_in         = neg_ff;
      voice_in       = voice_ff;
      mode_in        = mode_ff;
      sweep_amt_in   = sweep_amt_ff;
      sweep_int_in   = sweep_int_ff;
      sweep_cnt_in   = sweep_cnt_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      den_in         = den_ff;
      cnt_in         = cnt_ff;
      tgt_sweep_in   = tgt_sweep_ff;
      tgt_chan_in    = tgt_chan_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_take;
      left_in        = left_ff;
      right_in       = right_ff;
      ch       = 2'd0;
      nf       = 11'd0;
      step_pos = 12'd0;
      active   = 1'b0;
      lev      = 16'sd0;
      sum_l    = 16'sd0;
      sum_r    = 16'sd0;
      sc       = 17'd0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && req_operation == fcstm_pkg::OP_WRITE) begin
               if (req_address[7:3] == fcstm_pkg::ADDR_FREQ_BASE[7:3]) begin
                  ch = req_address[2:1];
                  nf = req_address[0] ? {req_write_data[2:0], freq_ff[ch][7:0]}
                                      : {freq_ff[ch][10:8], req_write_data};
                  freq_in[ch]  = nf;
                  rem_in       = 17'd0;
                  quo_in       = fcstm_pkg::SPAN_DIVIDEND;
                  den_in       = 17'(12'(fcstm_pkg::FREQ_SPAN) - {1'b0, nf});
                  cnt_in       = 5'd0;
                  tgt_sweep_in = 1'b0;
                  tgt_chan_in  = ch;
                  state_in     = ST_DIVA;
               end else if (req_address[7:2] == fcstm_pkg::ADDR_VOL_BASE[7:2]) begin
                  ch = req_address[1:0];
                  vol_l_in[ch] = req_write_data[7:4];
                  vol_r_in[ch] = req_write_data[3:0];
                  if (ch == 2'd1) begin
                     voice_in = req_write_data;
                  end
               end else if (req_address == fcstm_pkg::ADDR_SWEEP_AMT) begin
                  sweep_amt_in = req_write_data;
               end else if (req_address == fcstm_pkg::ADDR_SWEEP_TIM) begin
                  rem_in       = 17'd0;
                  quo_in       = fcstm_pkg::SWEEP_DIVIDEND;
                  den_in       = 17'(req_write_data) + 17'd1;
                  cnt_in       = 5'd0;
                  tgt_sweep_in = 1'b1;
                  state_in     = ST_DIVA;
               end else if (req_address == fcstm_pkg::ADDR_CONTROL) begin
                  enable_in = req_write_data[NCH-1:0];
                  mode_in   = req_write_data[7:5];
               end
            end else if (req_take) begin
               // sample tick: advance every running channel in parallel
               for (int c = 0; c < NCH; c++) begin
                  active = enable_ff[c]
                         & ~((c == 1) & mode_ff[0])
                         & ~((c == 3) & mode_ff[2]);
                  lev = neg_ff[c] ? -$signed(fcstm_pkg::TONE_LEVEL)
                                  : $signed(fcstm_pkg::TONE_LEVEL);
                  if (active) begin
                     step_pos = pos_ff[c] + 12'd1;
                     if (step_pos >= (period_ff[c] >> 1)) begin
                        pos_in[c] = 12'd0;
                        neg_in[c] = ~neg_ff[c];
                     end else begin
                        pos_in[c] = step_pos;
                     end
                     sum_l = sum_l + $signed({12'd0, vol_l_ff[c]}) * lev;
                     sum_r = sum_r + $signed({12'd0, vol_r_ff[c]}) * lev;
                  end else if (enable_ff[c] && c == 1) begin
                     // voice mode: raw signed byte, no volume weighting
                     sum_l = sum_l + $signed({{8{voice_ff[7]}}, voice_ff});
                     sum_r = sum_r + $signed({{8{voice_ff[7]}}, voice_ff});
                  end
               end
               left_in      = sum_l <<< 5;
               right_in     = sum_r <<< 5;
               rsp_valid_in = 1'b1;

               // channel 2 sweep; position is kept, period reloads
               if (enable_ff[2] && mode_ff[1] && sweep_int_ff != 17'd0) begin
                  sc = sweep_cnt_ff + 17'd1;
                  if (sc >= sweep_int_ff) begin
                     sweep_cnt_in = 17'd0;
                     nf = freq_ff[2] + {{3{sweep_amt_ff[7]}}, sweep_amt_ff};
                     freq_in[2]   = nf;
                     rem_in       = 17'd0;
                     quo_in       = fcstm_pkg::SPAN_DIVIDEND;
                     den_in       = 17'(12'(fcstm_pkg::FREQ_SPAN) - {1'b0, nf});
                     cnt_in       = 5'd0;
                     tgt_sweep_in = 1'b0;
                     tgt_chan_in  = 2'd2;
                     state_in     = ST_DIVA;
                  end else begin
                     sweep_cnt_in = sc;
                  end
               end
            end
         end
         ST_DIVA: begin
            rem_in = trial_ge ? 17'(trial - {1'b0, den_ff}) : trial[16:0];
            quo_in = quotient;
            cnt_in = cnt_ff + 5'd1;
            if (div_last) begin
               // second pass: sample rate over the first quotient
               rem_in   = 17'd0;
               quo_in   = sample_rate_ff;
               den_in   = quotient;
               cnt_in   = 5'd0;
               state_in = ST_DIVB;
            end
         end
         ST_DIVB: begin
            rem_in = trial_ge ? 17'(trial - {1'b0, den_ff}) : trial[16:0];
            quo_in = quotient;
            cnt_in = cnt_ff + 5'd1;
            if (div_last) begin
               if (tgt_sweep_ff) begin
                  sweep_int_in = quotient;
               end else begin
                  period_in[tgt_chan_ff] = quotient[11:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         sample_rate_ff <= fcstm_pkg::SAMPLE_RATE_RESET;
         for (int c = 0; c < NCH; c++) begin
            freq_ff[c]   <= 11'd0;
            period_ff[c] <= 12'd0;
            pos_ff[c]    <= 12'd0;
            vol_l_ff[c]  <= 4'd0;
            vol_r_ff[c]  <= 4'd0;
         end
         enable_ff    <= '0;
         neg_ff       <= '0;
         voice_ff     <= 8'd0;
         mode_ff      <= 3'd0;
         sweep_amt_ff <= 8'd0;
         sweep_int_ff <= 17'd0;
         sweep_cnt_ff <= 17'd0;
         cnt_ff       <= 5'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         sample_rate_ff <= sample_rate_in;
         freq_ff        <= freq_in;
         period_ff      <= period_in;
         pos_ff         <= pos_in;
         vol_l_ff       <= vol_l_in;
         vol_r_ff       <= vol_r_in;
         enable_ff      <= enable_in;
         neg_ff         <= neg_in;
         voice_ff       <= voice_in;
         mode_ff        <= mode_in;
         sweep_amt_ff   <= sweep_amt_in;
         sweep_int_ff   <= sweep_int_in;
         sweep_cnt_ff   <= sweep_cnt_in;
         cnt_ff         <= cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      den_ff       <= den_in;
      tgt_sweep_ff <= tgt_sweep_in;
      tgt_chan_ff  <= tgt_chan_in;
      left_ff      <= left_in;
      right_ff     <= right_in;
   end

`ifndef SYNTHESIS
   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("input taken while divider busy");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (cnt_ff < 5'(fcstm_pkg::DIV_WIDTH)))
      else $error("divider step count out of range");

   a_tick_result: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_operation == fcstm_pkg::OP_TICK) |=> rsp_valid_ff)
      else $error("tick gave no result");

   a_divb_after_diva: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVA && div_last) |=> (state_ff == ST_DIVB && cnt_ff == 5'd0))
      else $error("second division pass did not start");
`endif

endmodule
